// ----- rtl/core/euler_to_rotation_matrix_core_assert.svh -----
// Assertion macros for the Euler angle to rotation matrix core.
// Included by the top level; no other dependencies.
`ifndef EULER_TO_ROTATION_MATRIX_CORE_ASSERT_SVH
`define EULER_TO_ROTATION_MATRIX_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define E2R_ASSERT_IMPL(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("assertion failed");
`define E2R_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("assertion failed");
`else
`define E2R_ASSERT_IMPL(label, clk, rst_n, cond, conseq)
`define E2R_ASSERT_NEXT(label, clk, rst_n, cond, conseq)
`endif
`endif

// ----- rtl/core/e2r_pkg.sv -----
// Types, constants and arctangent table for the Euler to rotation matrix core.
// No dependencies.
package e2r_pkg;
    localparam int ANGLE_BITS = 16;
    localparam int COEFF_FRAC_BITS = 14;
    localparam int OUT_BITS = 16;
    localparam int CORDIC_STEPS = 30;
    localparam int WORK_FRAC = 30;
    localparam int CW = 34;
    localparam int ZW = 33;
    localparam int PW = 64;
    localparam int LAT = CORDIC_STEPS + 5;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] roll_angle;
        logic signed [ANGLE_BITS-1:0] pitch_angle;
        logic signed [ANGLE_BITS-1:0] heading_angle;
    } t_req;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] m00;
        logic signed [OUT_BITS-1:0] m01;
        logic signed [OUT_BITS-1:0] m02;
        logic signed [OUT_BITS-1:0] m10;
        logic signed [OUT_BITS-1:0] m11;
        logic signed [OUT_BITS-1:0] m12;
        logic signed [OUT_BITS-1:0] m20;
        logic signed [OUT_BITS-1:0] m21;
        logic signed [OUT_BITS-1:0] m22;
    } t_rsp;

    typedef struct packed {
        logic signed [WORK_FRAC+1:0] s;
        logic signed [WORK_FRAC+1:0] c;
    } t_sc;

    function automatic logic signed [ZW-1:0] atan_at(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0: v = 32'h20000000; 5'd1: v = 32'h12E4051D; 5'd2: v = 32'h09FB385B;
            5'd3: v = 32'h051111D4; 5'd4: v = 32'h028B0D43; 5'd5: v = 32'h0145D7E1;
            5'd6: v = 32'h00A2F61E; 5'd7: v = 32'h00517C55; 5'd8: v = 32'h0028BE53;
            5'd9: v = 32'h00145F2E; 5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3; 5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C; 5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F; 5'd19: v = 32'h00000517; 5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145; 5'd22: v = 32'h000000A2; 5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000028; 5'd25: v = 32'h00000014; 5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005; 5'd28: v = 32'h00000002; 5'd29: v = 32'h00000001;
            default: v = 32'h0;
        endcase
        return signed'({1'b0, v});
    endfunction

    // round to nearest, ties away from zero, by s bits
    function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v,
                                                 input int s);
        logic [PW-1:0] m;
        m = v[PW-1] ? (~v + 1'b1) : v;
        m = (m + (64'd1 << (s - 1))) >> s;
        return v[PW-1] ? signed'(~m + 1'b1) : signed'(m);
    endfunction
endpackage

// ----- rtl/core/euler_to_rotation_matrix_core.sv -----
// Channel   Ports                       Handshake
// request   i_start, i_req              accepted when i_start && !o_busy
// result    o_done, o_rsp               one cycle strobe, no backpressure
// One request per cycle; results come back in request order.
// The pipeline is the 30-stage CORDIC plus the product and rounding stages.
// o_busy is held low after reset; synchronous active-low reset clears valid bits.
// Top level; depends on e2r_pkg, e2r_cordic, e2r_matrix and the assertion header.
`include "euler_to_rotation_matrix_core_assert.svh"
module euler_to_rotation_matrix_core import e2r_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_done,
    output t_rsp o_rsp
);
    t_sc w_r, w_p, w_h;
    logic [LAT-1:0] r_vld;

    assign o_busy = 1'b0;

    e2r_cordic u_r (.i_clk(i_clk), .i_angle(i_req.roll_angle), .o_sc(w_r));
    e2r_cordic u_p (.i_clk(i_clk), .i_angle(i_req.pitch_angle), .o_sc(w_p));
    e2r_cordic u_h (.i_clk(i_clk), .i_angle(i_req.heading_angle), .o_sc(w_h));
    e2r_matrix u_m (.i_clk(i_clk), .i_r(w_r), .i_p(w_p), .i_h(w_h), .o_m(o_rsp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_start & ~o_busy};
        end
    end
    assign o_done = r_vld[LAT-1];

    `E2R_ASSERT_NEXT(a_done_follows, i_clk, i_rst_n, r_vld[LAT-2], o_done)
    `E2R_ASSERT_IMPL(a_m20_range, i_clk, i_rst_n, o_done,
        (o_rsp.m20 <= 16'sd16384) && (o_rsp.m20 >= -16'sd16384))
endmodule

// ----- rtl/core/e2r_cordic.sv -----
// Pipelined CORDIC sine/cosine, one rotation step per stage.
// Depends on e2r_pkg.
module e2r_cordic import e2r_pkg::*; (
    input  logic                  i_clk,
    input  logic [ANGLE_BITS-1:0] i_angle,
    output t_sc                   o_sc
);
    logic signed [CW-1:0] r_x [0:CORDIC_STEPS];
    logic signed [CW-1:0] r_y [0:CORDIC_STEPS];
    logic signed [ZW-1:0] r_z [0:CORDIC_STEPS];
    logic                 r_f [0:CORDIC_STEPS];
    logic [31:0] n_p, n_q;
    logic        n_flip;
    logic signed [CW-1:0] n_xo, n_yo;
    localparam logic signed [CW-1:0] ONE = CW'(64'd1 << WORK_FRAC);

    always_comb begin
        n_p = {i_angle, {(32-ANGLE_BITS){1'b0}}};
        n_flip = n_p[31] ^ n_p[30];
        n_q = n_flip ? n_p + 32'h80000000 : n_p;
    end

    always_ff @(posedge i_clk) begin
        r_x[0] <= CW'(652032874);
        r_y[0] <= '0;
        r_z[0] <= signed'({n_q[31], n_q});
        r_f[0] <= n_flip;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!r_z[i][ZW-1]) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - atan_at(5'(i));
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + atan_at(5'(i));
            end
            r_f[i+1] <= r_f[i];
        end
    end

    always_comb begin
        n_xo = r_f[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
        n_yo = r_f[CORDIC_STEPS] ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];
        if (n_xo > ONE) n_xo = ONE;
        if (n_xo < -ONE) n_xo = -ONE;
        if (n_yo > ONE) n_yo = ONE;
        if (n_yo < -ONE) n_yo = -ONE;
    end

    always_ff @(posedge i_clk) begin
        o_sc.c <= n_xo[WORK_FRAC+1:0];
        o_sc.s <= n_yo[WORK_FRAC+1:0];
    end
endmodule

// ----- rtl/core/e2r_matrix.sv -----
// Pipelined products, sums, rounding and saturation to matrix elements.
// Depends on e2r_pkg.
module e2r_matrix import e2r_pkg::*; (
    input  logic i_clk,
    input  t_sc  i_r,
    input  t_sc  i_p,
    input  t_sc  i_h,
    output t_rsp o_m
);
    typedef logic signed [PW-1:0] t_w;
    typedef logic signed [WORK_FRAC+1:0] t_n;
    t_n r_a0, r_a1, r_sh, r_ch;
    t_w r_t [0:8];
    t_w r_u [0:8];
    localparam int RS = 2 * WORK_FRAC - COEFF_FRAC_BITS;
    localparam t_w ONEO = t_w'(64'd1 << COEFF_FRAC_BITS);

    function automatic logic signed [OUT_BITS-1:0] fin(input t_w v);
        t_w r;
        r = rnd(v, RS);
        if (r > ONEO) r = ONEO;
        if (r < -ONEO) r = -ONEO;
        return r[OUT_BITS-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        r_a0 <= t_n'(rnd(t_w'(i_p.s) * t_w'(i_r.s), WORK_FRAC));
        r_a1 <= t_n'(rnd(t_w'(i_r.c) * t_w'(i_p.s), WORK_FRAC));
        r_sh <= i_h.s; r_ch <= i_h.c;
        r_t[0] <= t_w'(i_p.c) * t_w'(i_h.c);
        r_t[3] <= t_w'(i_p.c) * t_w'(i_h.s);
        r_t[6] <= -(t_w'(i_p.s) <<< WORK_FRAC);
        r_t[7] <= t_w'(i_r.s) * t_w'(i_p.c);
        r_t[8] <= t_w'(i_r.c) * t_w'(i_p.c);
        r_t[1] <= t_w'(i_r.c) * t_w'(i_h.s);
        r_t[2] <= t_w'(i_h.s) * t_w'(i_r.s);
        r_t[4] <= t_w'(i_r.c) * t_w'(i_h.c);
        r_t[5] <= t_w'(i_r.s) * t_w'(i_h.c);
    end

    always_ff @(posedge i_clk) begin
        r_u[0] <= r_t[0];
        r_u[3] <= r_t[3];
        r_u[6] <= r_t[6];
        r_u[7] <= r_t[7];
        r_u[8] <= r_t[8];
        r_u[1] <= t_w'(r_a0) * t_w'(r_ch) - r_t[1];
        r_u[2] <= t_w'(r_a1) * t_w'(r_ch) + r_t[2];
        r_u[4] <= t_w'(r_a0) * t_w'(r_sh) + r_t[4];
        r_u[5] <= t_w'(r_a1) * t_w'(r_sh) - r_t[5];
    end

    always_ff @(posedge i_clk) begin
        o_m.m00 <= fin(r_u[0]); o_m.m01 <= fin(r_u[1]); o_m.m02 <= fin(r_u[2]);
        o_m.m10 <= fin(r_u[3]); o_m.m11 <= fin(r_u[4]); o_m.m12 <= fin(r_u[5]);
        o_m.m20 <= fin(r_u[6]); o_m.m21 <= fin(r_u[7]); o_m.m22 <= fin(r_u[8]);
    end
endmodule

// ----- tb/euler_to_rotation_matrix_core_tb.sv -----
// Testbench for euler_to_rotation_matrix_core: random and corner attitude requests
// checked against a CORDIC-based direction cosine matrix predictor.
// Depends on e2r_pkg and the core RTL.
`timescale 1ns / 100ps

module euler_to_rotation_matrix_core_tb;
    import e2r_pkg::*;

    class dcm_scoreboard;
        t_rsp   pending[$];
        int     errors;

        function longint round_shr(longint v, int s);
            longint unsigned m;
            m = (v < 0) ? longint'(-v) : v;
            m = (m + (64'd1 << (s - 1))) >> s;
            return (v < 0) ? -longint'(m) : longint'(m);
        endfunction

        function longint sat_one(longint v, longint lim);
            if (v > lim) return lim;
            if (v < -lim) return -lim;
            return v;
        endfunction

        function void sin_cos(logic [15:0] ang, output longint s, output longint c);
            logic [31:0] ph;
            longint      x, y, z, dx, dy;
            longint      tab[30];
            bit          flip;
            tab = '{32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
                    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
                    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
                    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
                    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
                    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
                    32'h00000002, 32'h00000001};
            ph = {ang, 16'h0};
            flip = (ph[31:30] == 2'd1) || (ph[31:30] == 2'd2);
            if (flip) ph = ph + 32'h80000000;
            z = longint'(signed'(ph));
            x = 652032874;
            y = 0;
            for (int i = 0; i < 30; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= tab[i];
                end else begin
                    x += dx; y -= dy; z += tab[i];
                end
            end
            if (flip) begin
                x = -x; y = -y;
            end
            c = sat_one(x, 64'sd1 << 30);
            s = sat_one(y, 64'sd1 << 30);
        endfunction

        function longint triple(longint a, longint b, longint d);
            return round_shr(a * b, 30) * d;
        endfunction

        function logic [15:0] to_q14(longint v60);
            longint r;
            r = sat_one(round_shr(v60, 46), 64'sd16384);
            return r[15:0];
        endfunction

        function void note_request(t_req r);
            longint sr, cr, sp, cp, sh, ch;
            t_rsp   m;
            sin_cos(r.roll_angle, sr, cr);
            sin_cos(r.pitch_angle, sp, cp);
            sin_cos(r.heading_angle, sh, ch);
            m.m00 = to_q14(cp * ch);
            m.m01 = to_q14(triple(sp, sr, ch) - cr * sh);
            m.m02 = to_q14(triple(cr, sp, ch) + sh * sr);
            m.m10 = to_q14(cp * sh);
            m.m11 = to_q14(triple(sr, sp, sh) + cr * ch);
            m.m12 = to_q14(triple(cr, sp, sh) - sr * ch);
            m.m20 = to_q14(-sp * (64'sd1 << 30));
            m.m21 = to_q14(sr * cp);
            m.m22 = to_q14(cr * cp);
            pending.push_back(m);
        endfunction

        function void check_result(t_rsp got);
            t_rsp  exp_m;
            string nm[9];
            nm = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_m = pending.pop_front();
            for (int k = 0; k < 9; k++)
                if (exp_m[143-16*k -: 16] !== got[143-16*k -: 16]) begin
                    $display("%0t: %s expected %0d actual %0d", $time, nm[k],
                             $signed(exp_m[143-16*k -: 16]), $signed(got[143-16*k -: 16]));
                    errors++;
                end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    t_req i_req;
    logic o_busy;
    logic o_done;
    t_rsp o_rsp;

    dcm_scoreboard sb;
    int            n_accepted;
    int            quiet_cycles;

    euler_to_rotation_matrix_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                sb.note_request(i_req);
                n_accepted++;
            end
            if (o_done) sb.check_result(o_rsp);
            if ((i_start && !o_busy) || o_done) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= 2000) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_request(t_req r);
        int target;
        i_start = 1'b1;
        i_req = r;
        target = n_accepted + 1;
        do @(negedge i_clk); while (n_accepted < target);
    endtask

    task automatic idle_burst();
        i_start = 1'b0;
        i_req = t_req'(48'({$urandom, $urandom}));
        repeat ($urandom_range(1, 15)) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_angle();
        logic [15:0] corner[12];
        corner = '{16'h0000, 16'h7FFF, 16'h8000, 16'h4000, 16'hC000, 16'h2000,
                   16'hE000, 16'h0001, 16'hFFFF, 16'h3FFF, 16'h4001, 16'h8001};
        if ($urandom_range(0, 3) == 0) return corner[$urandom_range(0, 11)];
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    initial begin
        logic [15:0] dir[12];
        t_req        r;
        sb = new();
        n_accepted = 0;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        dir = '{16'h0000, 16'h7FFF, 16'h8000, 16'h4000, 16'hC000, 16'h2000,
                16'hE000, 16'h0001, 16'hFFFF, 16'h3FFF, 16'h4001, 16'h8001};
        foreach (dir[k]) begin
            r.roll_angle = dir[k];
            r.pitch_angle = dir[(k + 3) % 12];
            r.heading_angle = dir[(k + 7) % 12];
            send_request(r);
        end
        for (int k = 0; k < 3; k++) begin
            r = '0;
            r[47-16*k -: 16] = 16'h8000;
            send_request(r);
            r[47-16*k -: 16] = 16'h7FFF;
            send_request(r);
        end

        for (int n = 0; n < 1900; n++) begin
            if (n < 1600 && $urandom_range(0, 7) == 0) idle_burst();
            r.roll_angle = pick_angle();
            r.pitch_angle = pick_angle();
            r.heading_angle = pick_angle();
            send_request(r);
        end
        i_start = 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
        if (sb.errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
